/* rtl/core/palette_fade_engine_assert.svh */
// Assertion macros for the palette fade engine checker.
// Needs signals named clk and rst in the scope of each use.
`ifndef PALETTE_FADE_ENGINE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define PFE_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("pfe: check failed");

// Next-cycle implication, masked during reset.
`define PFE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("pfe: check failed");

// State seen right after a reset cycle.
`define PFE_ASSERT_AFTER_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pfe: reset check failed");

`endif

/* rtl/core/pfe_pkg.sv */
// Shared types and constants for the palette fade engine.
// No dependencies; compiled first.
package pfe_pkg;

  localparam int COLOR_W = 15;
  localparam int COMP_W  = 5;
  localparam int IDX_W   = 8;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 16;
  localparam int LANES   = 3;

  localparam logic [CNT_W-1:0] STEP_COUNT_RST = 16'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STEP   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // divider request: start pulse and divisor
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  // 5-bit component of an RGB15 color, lane 0 red, 1 green, 2 blue
  function automatic logic [COMP_W-1:0] comp_of(input logic [COLOR_W-1:0] c,
                                                input int unsigned lane);
    return c[lane*COMP_W +: COMP_W];
  endfunction

endpackage

/* rtl/core/pfe_ifs.sv */
// Valid/ready channels of the palette fade engine: item in, result out, config.
// Depends on pfe_pkg.
interface pfe_in_if;
  import pfe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [IDX_W-1:0]     entry_index;
  logic [COLOR_W-1:0]   start_color;
  logic [COLOR_W-1:0]   target_color;
  modport source (output valid, mode, entry_index, start_color, target_color,
                  input ready);
  modport sink   (input valid, mode, entry_index, start_color, target_color,
                  output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     out_index;
  logic [COLOR_W-1:0]   color_out;
  modport source (output valid, out_index, color_out, input ready);
  modport sink   (input valid, out_index, color_out, output ready);
endinterface

interface pfe_cfg_if;
  import pfe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CNT_W-1:0]     step_count;
  modport source (output valid, step_count, input ready);
  modport sink   (input valid, step_count, output ready);
endinterface

/* rtl/core/palette_fade_engine.sv */
// Palette fade engine. Holds ENTRIES palette entries, each with a current
// color in 5.FRAC_BITS fixed point per component, a signed per-step delta
// and a target color. One word in gives one word out, with out_index equal to
// entry_index. mode 0 loads an entry (start/target; color_out echoes the
// start), 1 advances it one step clamped at the target, 2 snaps it to the
// target, 3 reads it back. step_count (reset 16, 0 acts as 1) is sampled at
// load. Entries hold nothing until loaded; touching an unloaded entry gives
// an undefined color. Indexes wrap modulo ENTRIES.
// Rate: one word at a time. Step, finish and read pass from accept to next
// accept through memory read, update and write-back/output. A load also
// waits on the shared restoring divider, which forms all three deltas at
// one quotient bit per cycle.
// The result sits in an output register, so the next word is taken while the
// previous result waits downstream. Config writes are always accepted.
// Depends on pfe_pkg, pfe_ifs, pfe_div, pfe_mem.
module palette_fade_engine #(
  parameter int ENTRIES   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  pfe_in_if.sink   item,
  pfe_out_if.source result,
  pfe_cfg_if.sink  cfg
);
  import pfe_pkg::*;

  localparam int CW = COMP_W + FRAC_BITS;          // current value width
  localparam int SW = CW + 1;                      // signed step width
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = COLOR_W + LANES * (SW + CW); // entry word
  localparam logic [CW:0] HALF = (CW + 1)'(2 ** (FRAC_BITS - 1));

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // idx mod ENTRIES by conditional subtraction of shifted ENTRIES
  function automatic logic [AW-1:0] entry_of(input logic [IDX_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (r >= (32'(ENTRIES) << k)) begin
        r = r - (32'(ENTRIES) << k);
      end
    end
    return AW'(r);
  endfunction

  state_t state, state_next;

  logic [CNT_W-1:0]   step_count;
  logic               out_valid, out_valid_next;
  logic [IDX_W-1:0]   out_index_q;
  logic [COLOR_W-1:0] color_out_q;

  // latched item
  mode_t              mode_q;
  logic [IDX_W-1:0]   idx_q;
  logic [COLOR_W-1:0] start_q, tgt_q;
  logic [AW-1:0]      addr_q;

  // entry read back and entry to write
  logic [WW-1:0]                 rd_data, wr_data;
  logic [LANES-1:0][CW-1:0]      rd_cur, new_cur, exec_cur, step_cur;
  logic [LANES-1:0][SW-1:0]      rd_st, new_st;
  logic [COLOR_W-1:0]            rd_tgt, new_tgt, exec_tgt;

  // step datapath
  logic [LANES-1:0][SW:0]        sum, tgt_ext;
  logic [LANES-1:0][CW-1:0]      tgt_fx;
  logic [LANES-1:0]              st_pos, st_neg;

  // load datapath
  div_req_t                      div_req;
  logic                          div_busy;
  logic [LANES-1:0][CW-1:0]      div_mag, div_quo;
  logic [LANES-1:0]              diff_neg;
  logic [LANES-1:0][COMP_W-1:0]  diff_mag;

  // output rounding
  logic [LANES-1:0][CW:0]        rnd_sum;
  logic [COLOR_W-1:0]            color_pack;

  logic accept, done_fire;

  assign accept    = item.valid && item.ready;
  assign done_fire = (state == S_DONE) && (!out_valid || result.ready);

  assign item.ready       = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.out_index = out_index_q;
  assign result.color_out = color_out_q;

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RD;
      S_RD:   state_next = S_EXEC;
      S_EXEC: state_next = (mode_q == MODE_LOAD) ? S_DIV : S_DONE;
      S_DIV:  if (!div_busy) state_next = S_DONE;
      S_DONE: if (done_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = done_fire ? 1'b1 : (out_valid && !result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      step_count <= STEP_COUNT_RST;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        step_count <= cfg.step_count;
      end
    end
  end

  // ---- entry store ----
  assign rd_cur = rd_data[LANES*CW-1:0];
  assign rd_st  = rd_data[LANES*CW +: LANES*SW];
  assign rd_tgt = rd_data[WW-1 -: COLOR_W];
  assign wr_data = {new_tgt, new_st, new_cur};

  pfe_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .WW    (WW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (done_fire),
    .wr_addr (addr_q),
    .wr_data (wr_data),
    .rd_addr (addr_q),
    .rd_data (rd_data)
  );

  // ---- step: add delta, clamp at target in the delta's direction ----
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      tgt_fx[c]  = {comp_of(rd_tgt, c), {FRAC_BITS{1'b0}}};
      tgt_ext[c] = {2'b00, tgt_fx[c]};
      sum[c]     = {2'b00, rd_cur[c]} + {rd_st[c][SW-1], rd_st[c]};
      st_neg[c]  = rd_st[c][SW-1];
      st_pos[c]  = !rd_st[c][SW-1] && (rd_st[c] != '0);
      if ((st_pos[c] && ($signed(sum[c]) > $signed(tgt_ext[c]))) ||
          (st_neg[c] && ($signed(sum[c]) < $signed(tgt_ext[c])))) begin
        step_cur[c] = tgt_fx[c];
      end else begin
        step_cur[c] = sum[c][CW-1:0];
      end
    end
  end

  always_comb begin
    exec_cur = rd_cur;
    exec_tgt = rd_tgt;
    unique case (mode_q)
      MODE_LOAD: begin
        exec_tgt = tgt_q;
        for (int c = 0; c < LANES; c++) begin
          exec_cur[c] = {comp_of(start_q, c), {FRAC_BITS{1'b0}}};
        end
      end
      MODE_STEP: begin
        exec_cur = step_cur;
      end
      MODE_FINISH: begin
        for (int c = 0; c < LANES; c++) begin
          exec_cur[c] = {comp_of(rd_tgt, c), {FRAC_BITS{1'b0}}};
        end
      end
      MODE_READ: begin
        exec_cur = rd_cur;
      end
    endcase
  end

  // ---- load: |target - start| << FRAC_BITS over step_count, sign applied after ----
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      diff_neg[c] = comp_of(tgt_q, c) < comp_of(start_q, c);
      diff_mag[c] = diff_neg[c] ? (comp_of(start_q, c) - comp_of(tgt_q, c))
                                : (comp_of(tgt_q, c) - comp_of(start_q, c));
      div_mag[c]  = {diff_mag[c], {FRAC_BITS{1'b0}}};
    end
  end

  assign div_req.start   = (state == S_EXEC) && (mode_q == MODE_LOAD);
  assign div_req.divisor = (step_count == '0) ? CNT_W'(1) : step_count;

  pfe_div #(
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_mag),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // ---- round half up and pack ----
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      rnd_sum[c] = {1'b0, new_cur[c]} + HALF;
    end
    color_pack = {rnd_sum[2][FRAC_BITS +: COMP_W],
                  rnd_sum[1][FRAC_BITS +: COMP_W],
                  rnd_sum[0][FRAC_BITS +: COMP_W]};
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode_t'(item.mode);
      idx_q   <= item.entry_index;
      start_q <= item.start_color;
      tgt_q   <= item.target_color;
      addr_q  <= entry_of(item.entry_index);
    end
    if (state == S_EXEC) begin
      new_cur <= exec_cur;
      new_st  <= rd_st;
      new_tgt <= exec_tgt;
    end
    if ((state == S_DIV) && !div_busy) begin
      for (int c = 0; c < LANES; c++) begin
        new_st[c] <= diff_neg[c] ? (SW'(0) - {1'b0, div_quo[c]}) : {1'b0, div_quo[c]};
      end
    end
    if (done_fire) begin
      out_index_q <= idx_q;
      color_out_q <= color_pack;
    end
  end

endmodule

/* rtl/core/pfe_div.sv */
// Three-lane restoring divider, one quotient bit per lane per cycle.
// Depends on pfe_pkg.
module pfe_div #(
  parameter int DW = 13
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pfe_pkg::div_req_t                     req,
  input  logic [pfe_pkg::LANES-1:0][DW-1:0]     dividend,
  output logic                                  busy,
  output logic [pfe_pkg::LANES-1:0][DW-1:0]     quotient
);
  import pfe_pkg::*;

  localparam int NW = $clog2(DW + 1);

  logic [NW-1:0]                   cnt;
  logic [CNT_W-1:0]                dvsr;
  logic [LANES-1:0][CNT_W-1:0]     rem, rem_next;
  logic [LANES-1:0][DW-1:0]        quo, quo_next;
  logic [LANES-1:0][CNT_W:0]       trial;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem[i], quo[i][DW-1]};
      if (trial[i] >= {1'b0, dvsr}) begin
        rem_next[i] = trial[i][CNT_W-1:0] - dvsr;
        quo_next[i] = {quo[i][DW-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][CNT_W-1:0];
        quo_next[i] = {quo[i][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= NW'(DW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvsr <= req.divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (cnt != '0) begin
      rem  <= rem_next;
      quo  <= quo_next;
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

/* rtl/core/pfe_mem.sv */
// Palette entry store: one write port, one read port with registered data.
// No package dependency.
module pfe_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WW    = 96
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [WW-1:0] rd_data
);

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/pfe_checker.sv */
// Port-level checks for the palette fade engine, bound to the top level.
// Depends on palette_fade_engine_assert.svh and palette_fade_engine.
`include "palette_fade_engine_assert.svh"

module pfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_index,
  input logic [14:0] color_out
);

  // one word in flight: input closes right after a take
  `PFE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a result needs at least the read and update cycles
  `PFE_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid))

  // a stalled result holds
  `PFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_index) && $stable(color_out))

  // reset leaves the block open with nothing pending
  `PFE_ASSERT_AFTER_RST(a_reset_state, !out_valid && in_ready)

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_index (result.out_index),
  .color_out (result.color_out)
);

/* sim/testbench.sv */
// Self-checking bench for palette_fade_engine: directed fades, step count
// extremes and random fades under random gaps and output stalls.
// Depends on pfe_pkg, pfe_ifs and the engine RTL.
`timescale 1ns / 100ps

module testbench;
  import pfe_pkg::*;

  localparam int FADE_ENTRIES   = 256;
  localparam int FRAC           = 8;
  localparam int WATCHDOG_LIMIT = 1000;   // idle cycles with no handshake anywhere
  localparam int SETTLE_CYCLES  = 8;      // extra wait once every result is back
  localparam int PHASE_WORDS    = 180;

  // one expected result word
  typedef struct packed {
    logic [IDX_W-1:0]   entry;
    logic [COLOR_W-1:0] color;
  } swatch_t;

  logic clk;
  logic rst;

  pfe_in_if  item ();
  pfe_out_if result ();
  pfe_cfg_if cfg ();

  palette_fade_engine u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  // shadow copy of the palette: 5.8 levels, signed per-step deltas, targets
  logic [COMP_W+FRAC-1:0]        level [FADE_ENTRIES][LANES];
  logic signed [COMP_W+FRAC:0]   delta [FADE_ENTRIES][LANES];
  logic [COLOR_W-1:0]            goal  [FADE_ENTRIES];
  logic [CNT_W-1:0]              fade_steps;

  swatch_t pending_swatches[$];
  bit      loaded [FADE_ENTRIES];
  int      loaded_list[$];
  int      mismatches;
  int      words_sent;
  int      stalled_cycles;
  bit      tx_gaps;
  bit      rx_gaps;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // round 5.8 to nearest, halves up
  function automatic logic [COMP_W-1:0] round_level(logic [COMP_W+FRAC-1:0] v);
    logic [COMP_W+FRAC:0] u;
    u = {1'b0, v} + (COMP_W + FRAC + 1)'(1 << (FRAC - 1));
    return u[FRAC +: COMP_W];
  endfunction

  // update the shadow palette for one accepted word, return the color it reports
  function automatic swatch_t fade_apply(mode_t m, logic [IDX_W-1:0] idx,
                                         logic [COLOR_W-1:0] start,
                                         logic [COLOR_W-1:0] tgt);
    swatch_t r;
    int e, lane, div, lvl, aim, sum, st;
    e = idx % FADE_ENTRIES;
    r.entry = idx;
    r.color = '0;
    div = (fade_steps == 0) ? 1 : int'(fade_steps);
    for (lane = 0; lane < LANES; lane++) begin
      case (m)
        MODE_LOAD: begin
          lvl = int'(start[lane*COMP_W +: COMP_W]) * (1 << FRAC);
          aim = int'(tgt[lane*COMP_W +: COMP_W]) * (1 << FRAC);
          level[e][lane] = (COMP_W + FRAC)'(lvl);
          delta[e][lane] = (COMP_W + FRAC + 1)'((aim - lvl) / div); // truncates toward zero
        end
        MODE_STEP: begin
          aim = int'(goal[e][lane*COMP_W +: COMP_W]) * (1 << FRAC);
          st  = int'(delta[e][lane]);
          sum = int'(level[e][lane]) + st;
          // clamp at the target in the direction of travel; zero step holds
          if (st > 0 && sum > aim) sum = aim;
          if (st < 0 && sum < aim) sum = aim;
          level[e][lane] = (COMP_W + FRAC)'(sum);
          r.color[lane*COMP_W +: COMP_W] = round_level(level[e][lane]);
        end
        MODE_FINISH: begin
          aim = int'(goal[e][lane*COMP_W +: COMP_W]) * (1 << FRAC);
          level[e][lane] = (COMP_W + FRAC)'(aim);
        end
        default: r.color[lane*COMP_W +: COMP_W] = round_level(level[e][lane]);
      endcase
    end
    if (m == MODE_LOAD) begin
      goal[e] = tgt;
      r.color = start;
    end else if (m == MODE_FINISH) begin
      r.color = goal[e];
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 15'h7fff;
    return COLOR_W'($urandom_range(0, 32767));
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic check_swatch(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
    swatch_t want;
    if (pending_swatches.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: entry %0d color %h", idx, color);
      mismatches++;
    end else begin
      want = pending_swatches.pop_front();
      if (want.entry !== idx || want.color !== color) begin
        if (mismatches < 10)
          $display("mismatch: entry exp %0d got %0d, color exp %h got %h",
                   want.entry, idx, want.color, color);
        mismatches++;
      end
    end
  endtask

  // send one word; valid stays high on return so back-to-back words need no toggle
  task automatic send_word(mode_t m, logic [IDX_W-1:0] idx,
                           logic [COLOR_W-1:0] start, logic [COLOR_W-1:0] tgt);
    int gap;
    int e;
    gap = tx_gaps ? pick_gap() : 0;
    e = idx % FADE_ENTRIES;
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.mode         <= m;
    item.entry_index  <= idx;
    item.start_color  <= start;
    item.target_color <= tgt;
    do @(posedge clk); while (!item.ready);
    pending_swatches.push_back(fade_apply(m, idx, start, tgt));
    words_sent++;
    if (m == MODE_LOAD && !loaded[e]) begin
      loaded[e] = 1'b1;
      loaded_list.push_back(e);
    end
  endtask

  // stop sending and wait until every expected word is back
  task automatic drain_results();
    item.valid <= 1'b0;
    do @(posedge clk); while (pending_swatches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_fade_steps(logic [CNT_W-1:0] n);
    drain_results();
    cfg.valid      <= 1'b1;
    cfg.step_count <= n;
    do @(posedge clk); while (!cfg.ready);
    fade_steps = n;
    cfg.valid <= 1'b0;
  endtask

  // a few entries loaded, stepped toward their targets with some noise, some finished
  task automatic run_fade();
    int ents[$];
    int k, i, e, steps, eff, r;
    k = $urandom_range(1, 4);
    for (i = 0; i < k; i++) begin
      e = $urandom_range(0, FADE_ENTRIES - 1);
      send_word(MODE_LOAD, IDX_W'(e), pick_color(), pick_color());
      ents.push_back(e);
    end
    eff = (fade_steps == 0) ? 1 : int'(fade_steps);
    steps = ((eff + 2 > 30) ? 30 : eff + 2) * k;
    for (i = 0; i < steps; i++) begin
      e = ents[$urandom_range(0, k - 1)];
      r = $urandom_range(0, 19);
      if (r == 0)      send_word(MODE_READ, IDX_W'(e), pick_color(), pick_color());
      else if (r == 1) send_word(MODE_FINISH, IDX_W'(e), pick_color(), pick_color());
      else if (r == 2) send_word(mode_t'($urandom_range(1, 3)), IDX_W'(pick_loaded()),
                                 pick_color(), pick_color());
      else if (r == 3) send_word(MODE_LOAD, IDX_W'($urandom_range(0, FADE_ENTRIES - 1)),
                                 pick_color(), pick_color());
      else             send_word(MODE_STEP, IDX_W'(e), pick_color(), pick_color());
    end
    foreach (ents[j])
      if ($urandom_range(0, 1))
        send_word(MODE_FINISH, IDX_W'(ents[j]), pick_color(), pick_color());
  endtask

  // reset count of 16: both directions, zero step, mixed directions, read back
  task automatic test_directed_fades();
    send_word(MODE_LOAD, 8'd0, 15'h0000, 15'h7fff);
    send_word(MODE_STEP, 8'd0, 15'h0000, 15'h0000);
    send_word(MODE_LOAD, 8'd255, 15'h7fff, 15'h0000);
    send_word(MODE_STEP, 8'd255, 15'h7fff, 15'h7fff);
    send_word(MODE_STEP, 8'd255, 15'h0000, 15'h7fff);
    send_word(MODE_FINISH, 8'd0, 15'h7fff, 15'h0000);
    send_word(MODE_READ, 8'd255, 15'h7fff, 15'h7fff);
    send_word(MODE_READ, 8'd0, 15'h0000, 15'h0000);
    // start equals target: step is zero and the color holds
    send_word(MODE_LOAD, 8'd128, 15'h1234, 15'h1234);
    send_word(MODE_STEP, 8'd128, 15'h0000, 15'h0000);
    // red and blue fall, green rises
    send_word(MODE_LOAD, 8'd7, 15'h5555, 15'h2aaa);
    send_word(MODE_STEP, 8'd7, 15'h2aaa, 15'h5555);
    send_word(MODE_READ, 8'd7, 15'h0000, 15'h7fff);
    send_word(MODE_FINISH, 8'd7, 15'h0000, 15'h0000);
  endtask

  task automatic test_step_count_extremes();
    // one step reaches the target, the next one clamps there
    set_fade_steps(16'd1);
    send_word(MODE_LOAD, 8'd3, 15'h0421, 15'h7bde);
    send_word(MODE_STEP, 8'd3, 15'h0000, 15'h0000);
    send_word(MODE_STEP, 8'd3, 15'h0000, 15'h0000);
    send_word(MODE_READ, 8'd3, 15'h0000, 15'h0000);
    // huge count: delta truncates to zero, entry stays until finished
    set_fade_steps(16'hffff);
    send_word(MODE_LOAD, 8'd4, 15'h0000, 15'h7fff);
    send_word(MODE_STEP, 8'd4, 15'h0000, 15'h0000);
    send_word(MODE_FINISH, 8'd4, 15'h0000, 15'h0000);
    // zero count acts as one
    set_fade_steps(16'd0);
    send_word(MODE_LOAD, 8'd5, 15'h7fff, 15'h0000);
    send_word(MODE_STEP, 8'd5, 15'h0000, 15'h0000);
  endtask

  task automatic test_random_fades();
    int phase, first, r;
    logic [CNT_W-1:0] n;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       n = 16'd16;
        1:       n = 16'd1;
        2:       n = 16'hffff;
        3:       n = 16'd0;
        default: n = CNT_W'($urandom_range(2, 40));
      endcase
      set_fade_steps(n);
      // first phase runs with no idling on either side
      tx_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
        run_fade();
        r = $urandom_range(0, 7);
        if (r == 0) drain_results();   // sender holds off until all words are back
      end
    end
  endtask

  // result side: check each accepted word, then drive ready for the next edge
  initial begin
    int stall;
    stall = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready)
        check_swatch(result.out_index, result.color_out);
      if (rst) begin
        result.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result.ready <= 1'b0;
      end else begin
        stall = rx_gaps ? pick_gap() : 0;
        result.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // watchdog: no handshake anywhere for too long ends the run
  always @(posedge clk) begin
    if (rst) begin
      stalled_cycles = 0;
    end else if ((item.valid && item.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL palette_fade_engine");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    words_sent = 0;
    tx_gaps    = 1'b0;
    rx_gaps    = 1'b0;
    fade_steps = STEP_COUNT_RST;
    rst               <= 1'b1;
    item.valid        <= 1'b0;
    item.mode         <= MODE_LOAD;
    item.entry_index  <= '0;
    item.start_color  <= '0;
    item.target_color <= '0;
    cfg.valid         <= 1'b0;
    cfg.step_count    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_fades();
    test_step_count_extremes();
    test_random_fades();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_swatches.size() == 0) begin
      $display("PASS palette_fade_engine");
    end else begin
      $display("FAIL palette_fade_engine");
    end
    $finish;
  end

endmodule
